>>> rtl/apq_pkg.sv
// apq_pkg: shared constants, codes and types of the aging priority queue
// used by apq_ctrl, apq_dp and aging_priority_queue; depends on nothing
package apq_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_W       = 5;

   // item field widths
   localparam int KIND_W  = 2;
   localparam int BPRIO_W = 8;
   localparam int TAG_W   = 8;
   localparam int PRIO_W  = 16;
   localparam int WAIT_W  = 16;
   localparam int PHASE_W = 8;
   localparam int STAT_W  = 2;
   localparam int CFG_W   = 8;
   localparam int CSR_IDX_W = 1;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AGING_INTERVAL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGING_STEP     = 1'd1;

   // configuration reset values
   localparam logic [CFG_W-1:0] INTERVAL_RESET = 8'd2;
   localparam logic [CFG_W-1:0] STEP_RESET     = 8'd20;

   // saturation limits
   localparam logic [PRIO_W-1:0] PRIO_MAX = 16'hFFFF;
   localparam logic [WAIT_W-1:0] WAIT_MAX = 16'hFFFF;

   // one stored entry of the slot ram
   typedef struct packed {
      logic [PRIO_W-1:0]  aged;
      logic [WAIT_W-1:0]  waited;
      logic [PHASE_W-1:0] phase;
      logic [TAG_W-1:0]   tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // controller to datapath
   typedef struct packed {
      logic             load;
      logic             scan_rd;
      logic [IDX_W-1:0] scan_idx;
      logic             commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

>>> rtl/aging_priority_queue.sv
// aging_priority_queue: top level, joins apq_ctrl and apq_dp
// depends on apq_pkg, apq_ctrl, apq_dp (and apq_ram through apq_dp)
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------------
//   req      | req_valid / req_stall      | req_kind, req_priority_req, req_tag
//   rsp      | rsp_valid / rsp_stall      | rsp_status, rsp_out_tag, rsp_out_priority,
//            |                            | rsp_occupancy
//   csr      | csr_valid / csr_ready      | csr_index, csr_wdata
//
// enqueue and the unused kind pass through capture, then commit
// dequeue and tick pass through capture, a scan that walks the single-read-port
// slot ram one entry a cycle, then drain and commit
// one item is in work at a time; the result register lets the next item in
// while an earlier result waits on rsp_stall, and commit waits for it to free
// reset clears valid bits, counts and config; the slot ram needs no clearing
// csr writes are always taken (csr_ready high)
module aging_priority_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [apq_pkg::KIND_W-1:0]      req_kind,
   input  logic [apq_pkg::BPRIO_W-1:0]     req_priority_req,
   input  logic [apq_pkg::TAG_W-1:0]       req_tag,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [apq_pkg::STAT_W-1:0]      rsp_status,
   output logic [apq_pkg::TAG_W-1:0]       rsp_out_tag,
   output logic [apq_pkg::PRIO_W-1:0]      rsp_out_priority,
   output logic [apq_pkg::OCC_W-1:0]       rsp_occupancy,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [apq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [apq_pkg::CFG_W-1:0]       csr_wdata
);

   apq_pkg::cmd_type cmd;
   apq_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   // sequencer
   apq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath
   apq_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_kind         (req_kind),
      .req_priority_req (req_priority_req),
      .req_tag          (req_tag),
      .csr_valid        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_priority (rsp_out_priority),
      .rsp_occupancy    (rsp_occupancy)
   );

   // an accepted item blocks the input until its result is committed
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken twice without a result in between");

   // a full rejection reports a full queue
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == apq_pkg::ST_FULL)
         |-> (rsp_occupancy == apq_pkg::OCC_W'(apq_pkg::QUEUE_DEPTH)))
      else $error("full status with queue not full");

   // an empty dequeue reports an empty queue and zero payload
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == apq_pkg::ST_EMPTY)
         |-> (rsp_occupancy == '0 && rsp_out_tag == '0 && rsp_out_priority == '0))
      else $error("empty status with entries held or payload set");

   // occupancy never exceeds the capacity
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= apq_pkg::OCC_W'(apq_pkg::QUEUE_DEPTH)))
      else $error("occupancy beyond capacity");

endmodule

>>> rtl/apq_ram.sv
// apq_ram: generic single write port, single read port ram with registered read
// depends on nothing
module apq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/apq_ctrl.sv
// apq_ctrl: sequencer of the aging priority queue, steps the slot scan
// depends on apq_pkg; drives apq_dp through cmd_type and reads sts_type
module apq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [apq_pkg::KIND_W-1:0]   req_kind,
   output logic                         req_stall,
   output apq_pkg::cmd_type             cmd,
   input  apq_pkg::sts_type             sts
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type                  state_ff;
   logic [apq_pkg::CNT_W-1:0]  cnt_ff;
   logic                       accept;
   logic                       scan_end;

   assign accept   = req_valid && (state_ff == S_IDLE);
   assign scan_end = (cnt_ff == apq_pkg::CNT_W'(apq_pkg::QUEUE_DEPTH));

   // state and scan counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (req_valid) begin
                  if (req_kind == apq_pkg::KIND_DEQUEUE || req_kind == apq_pkg::KIND_TICK) begin
                     state_ff <= S_SCAN;
                  end else begin
                     state_ff <= S_FINISH;
                  end
               end
            end
            S_SCAN: begin
               // last read data is consumed in the cycle the count hits depth
               if (scan_end) begin
                  state_ff <= S_FINISH;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_FINISH: begin
               if (sts.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // commands
   assign req_stall    = (state_ff != S_IDLE);
   assign cmd.load     = accept;
   assign cmd.scan_rd  = (state_ff == S_SCAN) && !scan_end;
   assign cmd.scan_idx = cnt_ff[apq_pkg::IDX_W-1:0];
   assign cmd.commit   = (state_ff == S_FINISH) && sts.out_free;

endmodule

>>> rtl/apq_dp.sv
// apq_dp: datapath of the aging priority queue: slot ram, valid bits,
// best-entry tracking, aging update, config and result registers
// depends on apq_pkg and apq_ram
module apq_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  apq_pkg::cmd_type                cmd,
   output apq_pkg::sts_type                sts,
   input  logic [apq_pkg::KIND_W-1:0]      req_kind,
   input  logic [apq_pkg::BPRIO_W-1:0]     req_priority_req,
   input  logic [apq_pkg::TAG_W-1:0]       req_tag,
   input  logic                            csr_valid,
   input  logic [apq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [apq_pkg::CFG_W-1:0]       csr_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [apq_pkg::STAT_W-1:0]      rsp_status,
   output logic [apq_pkg::TAG_W-1:0]       rsp_out_tag,
   output logic [apq_pkg::PRIO_W-1:0]      rsp_out_priority,
   output logic [apq_pkg::OCC_W-1:0]       rsp_occupancy
);

   // item registers
   logic [apq_pkg::KIND_W-1:0]  kind_ff;
   logic [apq_pkg::BPRIO_W-1:0] prio_ff;
   logic [apq_pkg::TAG_W-1:0]   tag_ff;

   // configuration
   logic [apq_pkg::CFG_W-1:0] interval_ff;
   logic [apq_pkg::CFG_W-1:0] step_ff;

   // occupancy state
   logic [apq_pkg::QUEUE_DEPTH-1:0] valid_ff;
   logic [apq_pkg::CNT_W-1:0]       occ_ff;

   // scan stage
   logic                      stg_vld_ff;
   logic [apq_pkg::IDX_W-1:0] stg_idx_ff;

   // best entry so far
   logic                       best_found_ff;
   logic [apq_pkg::IDX_W-1:0]  best_idx_ff;
   logic [apq_pkg::PRIO_W-1:0] best_prio_ff;
   logic [apq_pkg::WAIT_W-1:0] best_wait_ff;
   logic [apq_pkg::TAG_W-1:0]  best_tag_ff;

   // result register
   logic                       rsp_valid_ff;
   logic [apq_pkg::STAT_W-1:0] rsp_status_ff;
   logic [apq_pkg::TAG_W-1:0]  rsp_tag_ff;
   logic [apq_pkg::PRIO_W-1:0] rsp_prio_ff;
   logic [apq_pkg::OCC_W-1:0]  rsp_occ_ff;

   // ram ports
   logic                      ram_wr_en;
   logic [apq_pkg::IDX_W-1:0] ram_wr_addr;
   apq_pkg::entry_type        ram_wr_data;
   apq_pkg::entry_type        ram_rd_data;

   // combinational helpers
   logic [apq_pkg::IDX_W-1:0]   free_idx;
   logic                        full;
   logic                        stg_live;
   logic                        better;
   logic                        do_enq;
   logic                        do_deq;
   logic [apq_pkg::PHASE_W:0]   phase_inc;
   logic [apq_pkg::PRIO_W:0]    prio_sum;
   apq_pkg::entry_type          aged_entry;
   logic [apq_pkg::CNT_W-1:0]   occ_in;
   logic [apq_pkg::STAT_W-1:0]  status_in;

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = apq_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = apq_pkg::IDX_W'(i);
         end
      end
   end

   assign full     = &valid_ff;
   assign stg_live = stg_vld_ff && valid_ff[stg_idx_ff];
   assign do_enq   = cmd.commit && (kind_ff == apq_pkg::KIND_ENQUEUE) && !full;
   assign do_deq   = cmd.commit && (kind_ff == apq_pkg::KIND_DEQUEUE) && best_found_ff;

   // tie-break: higher aged priority, then longer wait, then earlier slot
   assign better = !best_found_ff
                || (ram_rd_data.aged > best_prio_ff)
                || ((ram_rd_data.aged == best_prio_ff) && (ram_rd_data.waited > best_wait_ff));

   // aging update of one entry
   always_comb begin
      aged_entry = ram_rd_data;
      if (ram_rd_data.waited != apq_pkg::WAIT_MAX) begin
         aged_entry.waited = ram_rd_data.waited + 1'b1;
      end
      phase_inc = {1'b0, ram_rd_data.phase} + 1'b1;
      prio_sum  = {1'b0, ram_rd_data.aged} + {{(apq_pkg::PRIO_W + 1 - apq_pkg::CFG_W){1'b0}}, step_ff};
      if (phase_inc >= {1'b0, interval_ff}) begin
         aged_entry.phase = '0;
         aged_entry.aged  = prio_sum[apq_pkg::PRIO_W] ? apq_pkg::PRIO_MAX
                                                      : prio_sum[apq_pkg::PRIO_W-1:0];
      end else begin
         aged_entry.phase = phase_inc[apq_pkg::PHASE_W-1:0];
      end
   end

   // ram write select: new entry on enqueue, aged entry during a tick scan
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = stg_idx_ff;
      ram_wr_data = aged_entry;
      if (do_enq) begin
         ram_wr_en          = 1'b1;
         ram_wr_addr        = free_idx;
         ram_wr_data.aged   = {{(apq_pkg::PRIO_W - apq_pkg::BPRIO_W){1'b0}}, prio_ff};
         ram_wr_data.waited = '0;
         ram_wr_data.phase  = '0;
         ram_wr_data.tag    = tag_ff;
      end else if (stg_live && (kind_ff == apq_pkg::KIND_TICK)) begin
         ram_wr_en = 1'b1;
      end
   end

   apq_ram #(
      .WIDTH (apq_pkg::ENTRY_W),
      .DEPTH (apq_pkg::QUEUE_DEPTH)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (cmd.scan_idx),
      .rd_data (ram_rd_data)
   );

   // result fields
   always_comb begin
      occ_in    = occ_ff;
      status_in = apq_pkg::ST_DONE;
      if (do_enq) begin
         occ_in = occ_ff + 1'b1;
      end else if (do_deq) begin
         occ_in = occ_ff - 1'b1;
      end
      if ((kind_ff == apq_pkg::KIND_ENQUEUE) && full) begin
         status_in = apq_pkg::ST_FULL;
      end else if ((kind_ff == apq_pkg::KIND_DEQUEUE) && !best_found_ff) begin
         status_in = apq_pkg::ST_EMPTY;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         prio_ff <= req_priority_req;
         tag_ff  <= req_tag;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= apq_pkg::INTERVAL_RESET;
         step_ff     <= apq_pkg::STEP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            apq_pkg::CSR_AGING_INTERVAL: interval_ff <= csr_wdata;
            apq_pkg::CSR_AGING_STEP:     step_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid bits, occupancy and scan stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         occ_ff     <= '0;
         stg_vld_ff <= 1'b0;
      end else begin
         stg_vld_ff <= cmd.scan_rd;
         occ_ff     <= occ_in;
         if (do_enq) begin
            valid_ff[free_idx] <= 1'b1;
         end else if (do_deq) begin
            valid_ff[best_idx_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      stg_idx_ff <= cmd.scan_idx;
   end

   // best-entry tracking over the dequeue scan
   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
      end else if (cmd.load) begin
         best_found_ff <= 1'b0;
      end else if (stg_live && (kind_ff == apq_pkg::KIND_DEQUEUE) && better) begin
         best_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_live && (kind_ff == apq_pkg::KIND_DEQUEUE) && better) begin
         best_idx_ff  <= stg_idx_ff;
         best_prio_ff <= ram_rd_data.aged;
         best_wait_ff <= ram_rd_data.waited;
         best_tag_ff  <= ram_rd_data.tag;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= status_in;
         rsp_tag_ff    <= do_deq ? best_tag_ff : '0;
         rsp_prio_ff   <= do_deq ? best_prio_ff : '0;
         rsp_occ_ff    <= apq_pkg::OCC_W'(occ_in);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_occupancy    = rsp_occ_ff;

endmodule
